// ===== hdl/ffca_pkg.sv =====
// ----------------------------------------------------------------------------
// ffca_pkg
// Shared field widths, status codes and controller/datapath signal groups
// for the first-fit chunk allocator.
// ----------------------------------------------------------------------------
package ffca_pkg;

	localparam int SIZE_W   = 16;
	localparam int START_W  = 8;
	localparam int COUNT_W  = 9;
	localparam int STATUS_W = 2;
	// chunk demand of a 16-bit byte size after rounding up
	localparam int NEED_W   = 17;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK      = 2'd0,
		ST_NOSPACE = 2'd1,
		ST_ZERO    = 2'd2,
		ST_RANGE   = 2'd3
	} status_t;

	typedef enum logic {
		FUNC_ALLOC   = 1'b0,
		FUNC_RELEASE = 1'b1
	} func_t;

	// result to load into the response register
	typedef enum logic [2:0] {
		RES_ALLOC_OK = 3'd0,
		RES_REL_OK   = 3'd1,
		RES_NOSPACE  = 3'd2,
		RES_ZERO     = 3'd3,
		RES_RANGE    = 3'd4
	} res_t;

	typedef struct packed {
		logic capture;
		logic clr_step;
		logic div_load;
		logic scan_start;
		logic scan_step;
		logic fill_alloc;
		logic fill_release;
		logic fill_step;
		logic load_result;
		res_t res;
	} cmd_t;

	typedef struct packed {
		logic clr_done;
		logic is_release;
		logic size_zero;
		logic range_bad;
		logic count_zero;
		logic too_big;
		logic found;
		logic scan_end;
		logic fill_last;
	} sts_t;

endpackage

// ===== hdl/ffca_req_if.sv =====
// ----------------------------------------------------------------------------
// ffca_req_if
// Request channel: allocate or release, with valid/ready handshake.
// ----------------------------------------------------------------------------
interface ffca_req_if;
	import ffca_pkg::*;

	logic                valid;
	logic                ready;
	logic                func;
	logic [SIZE_W-1:0]   size_bytes;
	logic [START_W-1:0]  release_start;
	logic [COUNT_W-1:0]  release_count;

	modport source (
		output valid, func, size_bytes, release_start, release_count,
		input  ready
	);

	modport sink (
		input  valid, func, size_bytes, release_start, release_count,
		output ready
	);

endinterface

// ===== hdl/ffca_rsp_if.sv =====
// ----------------------------------------------------------------------------
// ffca_rsp_if
// Response channel: status, granted start and chunk count.
// ----------------------------------------------------------------------------
interface ffca_rsp_if;
	import ffca_pkg::*;

	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic [START_W-1:0]  start_chunk;
	logic [COUNT_W-1:0]  chunk_count;

	modport source (
		output valid, status, start_chunk, chunk_count,
		input  ready
	);

	modport sink (
		input  valid, status, start_chunk, chunk_count,
		output ready
	);

endinterface

// ===== hdl/first_fit_chunk_allocator_top.sv =====
// ----------------------------------------------------------------------------
// first_fit_chunk_allocator_top
// First-fit allocator of contiguous chunk runs over a one-bit free map.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one request: func 0 allocates ceil(size_bytes / CHUNK_BYTES)
//   chunks at the lowest free run, func 1 frees release_count chunks from
//   release_start. rsp returns one response per request: status, start_chunk
//   and chunk_count (both zero unless status is ok).
//   One request is worked at a time; req.ready is high only when idle.
//   An allocate scans the map one chunk per cycle through the memory read
//   port and stops at the first fitting run.
//   After reset the free map is set to all free by a clearing pass during
//   which no request is taken.
//   A stalled response is held in the output register; the next request is
//   still accepted and works until its own response is due.
// ----------------------------------------------------------------------------
module first_fit_chunk_allocator_top #(
	parameter int POOL_CHUNKS = 256,
	parameter int CHUNK_BYTES = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	ffca_req_if.sink    req,
	ffca_rsp_if.source  rsp
);
	import ffca_pkg::*;

	cmd_t cmd;
	sts_t sts;

	ffca_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.cmd       (cmd),
		.sts       (sts)
	);

	ffca_dp #(
		.POOL_CHUNKS (POOL_CHUNKS),
		.CHUNK_BYTES (CHUNK_BYTES)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.func          (req.func),
		.size_bytes    (req.size_bytes),
		.release_start (req.release_start),
		.release_count (req.release_count),
		.status        (rsp.status),
		.start_chunk   (rsp.start_chunk),
		.chunk_count   (rsp.chunk_count)
	);

	// a new request never lands while a scan or fill is running
	a_accept_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready) |-> (!cmd.scan_step && !cmd.fill_step))
		else $error("request accepted during scan or fill");

	// clearing pass and run fill never share the write port
	a_one_writer: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.clr_step && cmd.fill_step))
		else $error("clear and fill write together");

	// a pending response is never overwritten
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_result |-> (!rsp.valid || rsp.ready))
		else $error("response overwritten while stalled");

	// a failed request carries no start or count
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && (rsp.status != ST_OK)) |->
		((rsp.start_chunk == '0) && (rsp.chunk_count == '0)))
		else $error("failed response with nonzero payload");

endmodule

// ===== hdl/ffca_dp.sv =====
// ----------------------------------------------------------------------------
// ffca_dp
// Datapath: free map memory, chunk rounding, first-fit scan, run fill and
// response register.
// ----------------------------------------------------------------------------
module ffca_dp #(
	parameter int POOL_CHUNKS = 256,
	parameter int CHUNK_BYTES = 64
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  ffca_pkg::cmd_t                 cmd,
	output ffca_pkg::sts_t                 sts,
	input  logic                           func,
	input  logic [ffca_pkg::SIZE_W-1:0]    size_bytes,
	input  logic [ffca_pkg::START_W-1:0]   release_start,
	input  logic [ffca_pkg::COUNT_W-1:0]   release_count,
	output logic [ffca_pkg::STATUS_W-1:0]  status,
	output logic [ffca_pkg::START_W-1:0]   start_chunk,
	output logic [ffca_pkg::COUNT_W-1:0]   chunk_count
);
	import ffca_pkg::*;

	localparam int IDX_W  = $clog2(POOL_CHUNKS);
	localparam int RUN_W  = $clog2(POOL_CHUNKS + 1);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(POOL_CHUNKS - 1);

	// ceil(size / CHUNK_BYTES) as (size + CHUNK_BYTES - 1) * M >> SH
	localparam int DIV_L  = $clog2(CHUNK_BYTES);
	localparam int DIV_SH = NEED_W + DIV_L;
	localparam int MUL_W  = NEED_W + 1;
	localparam int PROD_W = NEED_W + MUL_W;
	localparam logic [63:0] DIV_M = ((64'd1 << DIV_SH) / 64'(CHUNK_BYTES)) + 64'd1;

	// captured request
	logic                func_q;
	logic [SIZE_W-1:0]   size_q;
	logic [START_W-1:0]  rel_start_q;
	logic [COUNT_W-1:0]  rel_count_q;
	logic [NEED_W-1:0]   need_q;

	// free map, one bit per chunk, 1 = free
	logic                map_mem [POOL_CHUNKS];

	logic [IDX_W-1:0]    clr_ptr_q;
	logic [IDX_W-1:0]    rd_addr_q;
	logic                rd_more_q;
	logic                rd_vld_s1;
	logic                rd_data_s1;
	logic [IDX_W-1:0]    rd_idx_s1;
	logic [RUN_W-1:0]    run_q;
	logic [IDX_W-1:0]    run_start_q;
	logic [IDX_W-1:0]    fill_ptr_q;
	logic [RUN_W-1:0]    fill_left_q;
	logic                fill_data_q;

	logic [STATUS_W-1:0] status_q;
	logic [START_W-1:0]  start_q;
	logic [COUNT_W-1:0]  count_q;

	logic [NEED_W-1:0]   div_num;
	logic [PROD_W-1:0]   div_prod;
	logic [RUN_W-1:0]    run_inc;
	logic [IDX_W-1:0]    found_start;
	logic                found;
	logic                wr_en;
	logic [IDX_W-1:0]    wr_addr;
	logic                wr_data;

	// round the byte size up to chunks
	assign div_num  = NEED_W'(size_q) + NEED_W'(CHUNK_BYTES - 1);
	assign div_prod = PROD_W'(div_num) * PROD_W'(DIV_M[MUL_W-1:0]);

	// run tracking on the registered map bit
	assign run_inc     = run_q + RUN_W'(1);
	assign found       = rd_vld_s1 && rd_data_s1 && (NEED_W'(run_inc) >= need_q);
	assign found_start = (run_q == '0) ? rd_idx_s1 : run_start_q;

	// status toward the controller
	always_comb begin
		sts            = '0;
		sts.clr_done   = (clr_ptr_q == LAST_IDX);
		sts.is_release = (func_q == FUNC_RELEASE);
		sts.size_zero  = (size_q == '0);
		sts.range_bad  = ((32'(rel_start_q) + 32'(rel_count_q)) > 32'(POOL_CHUNKS));
		sts.count_zero = (rel_count_q == '0);
		sts.too_big    = (need_q > NEED_W'(POOL_CHUNKS));
		sts.found      = found;
		sts.scan_end   = rd_vld_s1 && (rd_idx_s1 == LAST_IDX) && !found;
		sts.fill_last  = (fill_left_q == RUN_W'(1));
	end

	// select the map write: clearing pass or run fill
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = fill_ptr_q;
		wr_data = fill_data_q;
		if (cmd.clr_step) begin
			wr_en   = 1'b1;
			wr_addr = clr_ptr_q;
			wr_data = 1'b1;
		end else if (cmd.fill_step) begin
			wr_en   = 1'b1;
		end
	end

	// map memory: one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (wr_en) begin
			map_mem[wr_addr] <= wr_data;
		end
		if (cmd.scan_step && rd_more_q) begin
			rd_data_s1 <= map_mem[rd_addr_q];
		end
	end

	// control registers of the clearing pass and scan
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_ptr_q <= '0;
			rd_more_q <= 1'b0;
			rd_vld_s1 <= 1'b0;
		end else begin
			if (cmd.clr_step) begin
				clr_ptr_q <= clr_ptr_q + IDX_W'(1);
			end
			if (cmd.scan_start) begin
				rd_more_q <= 1'b1;
				rd_vld_s1 <= 1'b0;
			end else if (cmd.scan_step) begin
				rd_vld_s1 <= rd_more_q;
				if (rd_more_q && (rd_addr_q == LAST_IDX)) begin
					rd_more_q <= 1'b0;
				end
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			func_q      <= func;
			size_q      <= size_bytes;
			rel_start_q <= release_start;
			rel_count_q <= release_count;
		end
		if (cmd.div_load) begin
			need_q <= NEED_W'(div_prod >> DIV_SH);
		end

		// advance the scan address and track the current free run
		if (cmd.scan_start) begin
			rd_addr_q <= '0;
			run_q     <= '0;
		end else if (cmd.scan_step) begin
			if (rd_more_q) begin
				rd_idx_s1 <= rd_addr_q;
				rd_addr_q <= rd_addr_q + IDX_W'(1);
			end
			if (rd_vld_s1) begin
				if (rd_data_s1) begin
					run_start_q <= found_start;
					run_q       <= run_inc;
				end else begin
					run_q <= '0;
				end
			end
		end

		// load and advance the run fill
		if (cmd.fill_alloc) begin
			run_start_q <= found_start;
			fill_ptr_q  <= found_start;
			fill_left_q <= RUN_W'(need_q);
			fill_data_q <= 1'b0;
		end else if (cmd.fill_release) begin
			fill_ptr_q  <= IDX_W'(rel_start_q);
			fill_left_q <= RUN_W'(rel_count_q);
			fill_data_q <= 1'b1;
		end else if (cmd.fill_step) begin
			fill_ptr_q  <= fill_ptr_q + IDX_W'(1);
			fill_left_q <= fill_left_q - RUN_W'(1);
		end

		// response register
		if (cmd.load_result) begin
			case (cmd.res)
				RES_ALLOC_OK: begin
					status_q <= ST_OK;
					start_q  <= START_W'(run_start_q);
					count_q  <= COUNT_W'(need_q);
				end
				RES_REL_OK: begin
					status_q <= ST_OK;
					start_q  <= rel_start_q;
					count_q  <= rel_count_q;
				end
				RES_NOSPACE: begin
					status_q <= ST_NOSPACE;
					start_q  <= '0;
					count_q  <= '0;
				end
				RES_ZERO: begin
					status_q <= ST_ZERO;
					start_q  <= '0;
					count_q  <= '0;
				end
				default: begin
					status_q <= ST_RANGE;
					start_q  <= '0;
					count_q  <= '0;
				end
			endcase
		end
	end

	assign status      = status_q;
	assign start_chunk = start_q;
	assign chunk_count = count_q;

endmodule

// ===== hdl/ffca_ctrl.sv =====
// ----------------------------------------------------------------------------
// ffca_ctrl
// Controller: sequences clearing, decode, rounding, scan, fill and response.
// ----------------------------------------------------------------------------
module ffca_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_ready,
	output logic            rsp_valid,
	input  logic            rsp_ready,
	output ffca_pkg::cmd_t  cmd,
	input  ffca_pkg::sts_t  sts
);
	import ffca_pkg::*;

	typedef enum logic [6:0] {
		S_CLEAR  = 7'b0000001,
		S_IDLE   = 7'b0000010,
		S_DECODE = 7'b0000100,
		S_CHECK  = 7'b0001000,
		S_SCAN   = 7'b0010000,
		S_FILL   = 7'b0100000,
		S_RESP   = 7'b1000000
	} state_t;

	state_t state_q, state_d;
	res_t   res_q, res_d;
	logic   out_valid_q;

	// next state and commands
	always_comb begin
		state_d   = state_q;
		res_d     = res_q;
		cmd       = '0;
		req_ready = 1'b0;
		unique case (state_q)
			S_CLEAR: begin
				cmd.clr_step = 1'b1;
				if (sts.clr_done) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.capture = 1'b1;
					state_d     = S_DECODE;
				end
			end
			S_DECODE: begin
				if (sts.is_release) begin
					if (sts.range_bad) begin
						res_d   = RES_RANGE;
						state_d = S_RESP;
					end else if (sts.count_zero) begin
						res_d   = RES_REL_OK;
						state_d = S_RESP;
					end else begin
						cmd.fill_release = 1'b1;
						res_d            = RES_REL_OK;
						state_d          = S_FILL;
					end
				end else if (sts.size_zero) begin
					res_d   = RES_ZERO;
					state_d = S_RESP;
				end else begin
					cmd.div_load = 1'b1;
					state_d      = S_CHECK;
				end
			end
			S_CHECK: begin
				if (sts.too_big) begin
					res_d   = RES_NOSPACE;
					state_d = S_RESP;
				end else begin
					cmd.scan_start = 1'b1;
					state_d        = S_SCAN;
				end
			end
			S_SCAN: begin
				if (sts.found) begin
					cmd.fill_alloc = 1'b1;
					res_d          = RES_ALLOC_OK;
					state_d        = S_FILL;
				end else if (sts.scan_end) begin
					res_d   = RES_NOSPACE;
					state_d = S_RESP;
				end else begin
					cmd.scan_step = 1'b1;
				end
			end
			S_FILL: begin
				cmd.fill_step = 1'b1;
				if (sts.fill_last) begin
					state_d = S_RESP;
				end
			end
			S_RESP: begin
				// hold until the response register is free
				if (!out_valid_q || rsp_ready) begin
					cmd.load_result = 1'b1;
					cmd.res         = res_q;
					state_d         = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			res_q       <= RES_ALLOC_OK;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			res_q   <= res_d;
			if (cmd.load_result) begin
				out_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign rsp_valid = out_valid_q;

endmodule

// ===== tb/first_fit_chunk_allocator_top_tb.sv =====
// ----------------------------------------------------------------------------
// first_fit_chunk_allocator_top_tb
// Drives allocate and release requests into the chunk allocator and checks
// every response against a free-map predictor kept inside the bench. The
// bench opens with directed corner requests, then runs randomized traffic in
// which most releases return runs that were granted earlier. Both channels
// idle at random, the response side holds off for one long stretch, and the
// request side pauses once until every response has come back.
// ----------------------------------------------------------------------------
module first_fit_chunk_allocator_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import ffca_pkg::*;

	localparam int POOL_CHUNKS  = 256;
	localparam int CHUNK_BYTES  = 64;
	localparam int RANDOM_REQS  = 1900;
	localparam int HOLD_CYCLES  = 3000;
	localparam int STALL_LIMIT  = 20000;
	localparam int TAIL_CYCLES  = 2 * POOL_CHUNKS + 16;
	localparam int REPORT_LIMIT = 10;

	typedef struct packed {
		func_t              op;
		logic [SIZE_W-1:0]  size_bytes;
		logic [START_W-1:0] rel_start;
		logic [COUNT_W-1:0] rel_count;
		logic               drain_first;
	} alloc_req_t;

	typedef struct packed {
		status_t            status;
		logic [START_W-1:0] start_chunk;
		logic [COUNT_W-1:0] chunk_count;
	} alloc_rsp_t;

	typedef struct packed {
		logic [START_W-1:0] first;
		logic [COUNT_W-1:0] len;
	} chunk_run_t;

	logic clk;
	logic arst_n;

	ffca_req_if req_bus();
	ffca_rsp_if rsp_bus();

	first_fit_chunk_allocator_top #(
		.POOL_CHUNKS (POOL_CHUNKS),
		.CHUNK_BYTES (CHUNK_BYTES)
	) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_bus),
		.rsp    (rsp_bus)
	);

	// free map as seen by the checker and by the request generator
	logic [POOL_CHUNKS-1:0] free_map;
	logic [POOL_CHUNKS-1:0] plan_map;

	alloc_req_t pending[$];
	alloc_rsp_t grants_due[$];
	chunk_run_t live_runs[$];

	int  total_reqs;
	int  req_accepted;
	int  stall_cycles;
	int  errors;
	int  hold_left;
	bit  hold_done;
	bit  req_taken;
	bit  timed_out;
	alloc_req_t offer;

	// work out the response to one request and update the given free map
	function automatic alloc_rsp_t chunk_outcome(inout logic [POOL_CHUNKS-1:0] map,
			input alloc_req_t r);
		alloc_rsp_t res;
		int need;
		int run;
		int run_first;
		int i;
		bit found;
		res = '{status: ST_OK, start_chunk: '0, chunk_count: '0};
		if (r.op == FUNC_ALLOC) begin
			need = (int'(r.size_bytes) + CHUNK_BYTES - 1) / CHUNK_BYTES;
			if (r.size_bytes == '0) begin
				res.status = ST_ZERO;
			end else if (need > POOL_CHUNKS) begin
				res.status = ST_NOSPACE;
			end else begin
				run = 0;
				run_first = 0;
				found = 1'b0;
				// scan upward for the lowest run of free chunks
				for (i = 0; i < POOL_CHUNKS && !found; i++) begin
					if (map[i]) begin
						if (run == 0)
							run_first = i;
						run++;
						if (run >= need)
							found = 1'b1;
					end else begin
						run = 0;
					end
				end
				if (found) begin
					for (i = run_first; i < run_first + need; i++)
						map[i] = 1'b0;
					res.start_chunk = START_W'(run_first);
					res.chunk_count = COUNT_W'(need);
				end else begin
					res.status = ST_NOSPACE;
				end
			end
		end else begin
			if (int'(r.rel_start) + int'(r.rel_count) > POOL_CHUNKS) begin
				res.status = ST_RANGE;
			end else begin
				for (i = int'(r.rel_start); i < int'(r.rel_start) + int'(r.rel_count); i++)
					map[i] = 1'b1;
				res.start_chunk = r.rel_start;
				res.chunk_count = r.rel_count;
			end
		end
		return res;
	endfunction

	// queue one request and track which runs it leaves allocated
	task automatic plan_request(input alloc_req_t r);
		alloc_rsp_t res;
		res = chunk_outcome(plan_map, r);
		if (r.op == FUNC_ALLOC && res.status == ST_OK)
			live_runs.push_back('{first: res.start_chunk, len: res.chunk_count});
		pending.push_back(r);
	endtask

	task automatic plan_alloc(input int size_bytes);
		alloc_req_t r;
		r.op          = FUNC_ALLOC;
		r.size_bytes  = SIZE_W'(size_bytes);
		r.rel_start   = START_W'($urandom);
		r.rel_count   = COUNT_W'($urandom);
		r.drain_first = 1'b0;
		plan_request(r);
	endtask

	task automatic plan_release(input int first, input int len);
		alloc_req_t r;
		r.op          = FUNC_RELEASE;
		r.size_bytes  = SIZE_W'($urandom);
		r.rel_start   = START_W'(first);
		r.rel_count   = COUNT_W'(len);
		r.drain_first = 1'b0;
		plan_request(r);
	endtask

	task automatic plan_random_traffic();
		int pick;
		int idx;
		int first;
		int len;
		chunk_run_t run;
		pick = $urandom_range(99);
		if (pick < 45 || (pick < 85 && live_runs.size() == 0)) begin
			// allocate: mostly small runs, some large, zero and oversize sizes
			pick = $urandom_range(99);
			if (pick < 70)
				plan_alloc($urandom_range(1024, 1));
			else if (pick < 85)
				plan_alloc($urandom_range(4096, 1));
			else if (pick < 90)
				plan_alloc(0);
			else if (pick < 95)
				plan_alloc($urandom_range(65535));
			else
				plan_alloc($urandom_range(16448, 16320));
		end else if (pick < 85) begin
			// return a run that was granted earlier
			idx = $urandom_range(live_runs.size() - 1);
			run = live_runs[idx];
			live_runs.delete(idx);
			plan_release(run.first, run.len);
		end else if (pick < 93 || live_runs.size() == 0) begin
			// release an arbitrary range, possibly past the pool end
			first = $urandom_range(POOL_CHUNKS - 1);
			len = ($urandom_range(1) == 0) ? $urandom_range(16) : $urandom_range(POOL_CHUNKS);
			plan_release(first, len);
		end else begin
			// release part of a granted run
			run = live_runs[$urandom_range(live_runs.size() - 1)];
			first = run.first + $urandom_range(run.len - 1);
			len = $urandom_range(run.first + run.len - first);
			plan_release(first, len);
		end
	endtask

	function automatic int traffic_phase();
		int ph;
		ph = (req_accepted * 3) / (total_reqs == 0 ? 1 : total_reqs);
		return (ph > 2) ? 2 : ph;
	endfunction

	function automatic int send_idle_pct();
		case (traffic_phase())
			0:       return 24;
			1:       return 82;
			default: return 0;
		endcase
	endfunction

	function automatic int rsp_idle_pct();
		case (traffic_phase())
			0:       return 82;
			1:       return 24;
			default: return 0;
		endcase
	endfunction

	// clock
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// offer the next request once the previous one is taken
	always @(negedge clk) begin
		if (arst_n && (!req_bus.valid || req_taken)) begin
			if (pending.size() != 0 &&
			    !(pending[0].drain_first && grants_due.size() != 0) &&
			    $urandom_range(99) >= send_idle_pct()) begin
				offer = pending.pop_front();
				req_bus.valid         <= 1'b1;
				req_bus.func          <= offer.op;
				req_bus.size_bytes    <= offer.size_bytes;
				req_bus.release_start <= offer.rel_start;
				req_bus.release_count <= offer.rel_count;
			end else begin
				req_bus.valid <= 1'b0;
			end
		end
	end

	// drive response ready, with one long hold-off at the start of the last phase
	always @(negedge clk) begin
		if (!hold_done && total_reqs != 0 && traffic_phase() == 2) begin
			hold_left = HOLD_CYCLES;
			hold_done = 1'b1;
		end
		if (hold_left > 0) begin
			hold_left--;
			rsp_bus.ready <= 1'b0;
		end else begin
			rsp_bus.ready <= ($urandom_range(99) >= rsp_idle_pct());
		end
	end

	// sample both channels: predict on each request, check each response
	always @(posedge clk) begin : watch_channels
		alloc_req_t got_req;
		alloc_rsp_t want;
		bit moved;
		moved = 1'b0;
		req_taken = 1'b0;
		if (arst_n) begin
			if (rsp_bus.valid && rsp_bus.ready) begin
				moved = 1'b1;
				if (grants_due.size() == 0) begin
					errors++;
					if (errors <= REPORT_LIMIT)
						$display("%0t: response with none outstanding: status %0d start %0d count %0d",
							$realtime, rsp_bus.status, rsp_bus.start_chunk, rsp_bus.chunk_count);
				end else begin
					want = grants_due.pop_front();
					if (rsp_bus.status !== want.status ||
					    rsp_bus.start_chunk !== want.start_chunk ||
					    rsp_bus.chunk_count !== want.chunk_count) begin
						errors++;
						if (errors <= REPORT_LIMIT)
							$display("%0t: expected status %0d start %0d count %0d, got %0d %0d %0d",
								$realtime, want.status, want.start_chunk, want.chunk_count,
								rsp_bus.status, rsp_bus.start_chunk, rsp_bus.chunk_count);
					end
				end
			end
			if (req_bus.valid && req_bus.ready) begin
				moved = 1'b1;
				got_req.op          = func_t'(req_bus.func);
				got_req.size_bytes  = req_bus.size_bytes;
				got_req.rel_start   = req_bus.release_start;
				got_req.rel_count   = req_bus.release_count;
				got_req.drain_first = 1'b0;
				grants_due.push_back(chunk_outcome(free_map, got_req));
				req_accepted++;
				req_taken = 1'b1;
			end
			stall_cycles = moved ? 0 : stall_cycles + 1;
		end
	end

	initial begin
		int i;
		arst_n                = 1'b0;
		req_bus.valid         = 1'b0;
		req_bus.func          = FUNC_ALLOC;
		req_bus.size_bytes    = '0;
		req_bus.release_start = '0;
		req_bus.release_count = '0;
		rsp_bus.ready         = 1'b0;
		free_map              = '1;
		plan_map              = '1;
		total_reqs            = 0;
		req_accepted          = 0;
		stall_cycles          = 0;
		errors                = 0;
		hold_left             = 0;
		hold_done             = 1'b0;
		req_taken             = 1'b0;
		timed_out             = 1'b0;

		// directed corners: zero size, rounding, oversize, full pool, range errors
		plan_alloc(0);
		plan_alloc(1);
		plan_alloc(CHUNK_BYTES);
		plan_alloc(CHUNK_BYTES + 1);
		plan_alloc(65535);
		plan_alloc(POOL_CHUNKS * CHUNK_BYTES + 1);
		plan_release(POOL_CHUNKS - 1, 2);
		plan_release(0, 0);
		plan_release(0, POOL_CHUNKS);
		plan_alloc(POOL_CHUNKS * CHUNK_BYTES);
		plan_alloc(1);
		plan_release(POOL_CHUNKS - 1, 1);
		plan_alloc(1);
		plan_release(100, 10);
		plan_release(105, 10);
		plan_alloc(15 * CHUNK_BYTES);
		plan_alloc(6 * CHUNK_BYTES);
		plan_release(0, POOL_CHUNKS);
		plan_alloc(65472);
		plan_alloc(POOL_CHUNKS * CHUNK_BYTES - 1);
		plan_release(1, POOL_CHUNKS - 1);
		plan_release(1, POOL_CHUNKS);
		plan_release(POOL_CHUNKS - 1, 0);
		plan_release(0, POOL_CHUNKS);
		live_runs.delete();

		for (i = 0; i < RANDOM_REQS; i++)
			plan_random_traffic();
		total_reqs = pending.size();
		// hold the sender once until every response is back
		pending[total_reqs / 2].drain_first = 1'b1;

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// wait for every request to be taken and answered
		while (!timed_out && !(req_accepted == total_reqs && grants_due.size() == 0)) begin
			@(negedge clk);
			if (stall_cycles >= STALL_LIMIT)
				timed_out = 1'b1;
		end
		if (!timed_out)
			repeat (TAIL_CYCLES) @(negedge clk);
		else
			$display("%0t: no handshake for %0d cycles", $realtime, STALL_LIMIT);

		if (!timed_out && errors == 0 && grants_due.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

// ===== sim.f =====
hdl/ffca_pkg.sv
hdl/ffca_req_if.sv
hdl/ffca_rsp_if.sv
hdl/ffca_dp.sv
hdl/ffca_ctrl.sv
hdl/first_fit_chunk_allocator_top.sv
tb/first_fit_chunk_allocator_top_tb.sv
